// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the Euler-to-quaternion block.
// Depends on nothing; files that assert take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition is followed in the next cycle by another.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/e2q_pkg.sv =====
// Package of the Euler-to-quaternion block: word formats, CORDIC constants,
// the data handed between CORDIC cells, and the fixed-point product helper.
`timescale 1ns / 1ps

package e2q_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int INNER_FRAC = 30;
   localparam int NUM_AXES   = 3;
   localparam int ATAN_LEN   = 32;

   localparam int AXIS_ROLL  = 0;
   localparam int AXIS_PITCH = 1;
   localparam int AXIS_YAW   = 2;

   // Reciprocal of the CORDIC gain in Q2.30.
   localparam logic signed [WORD_WIDTH-1:0] INV_GAIN = 32'sd652032874;

   // atan(2^-i) in 32-bit binary angle units, where 2^31 stands for pi.
   localparam logic signed [WORD_WIDTH-1:0] ATAN_TABLE [ATAN_LEN] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10680094,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,
      32'sd41,        32'sd20,        32'sd10,        32'sd5,
      32'sd3,         32'sd1,         32'sd1,         32'sd0
   };

   // One axis inside the CORDIC chain: cosine and sine in Q2.30, residual angle.
   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] cos_v;
      logic signed [WORD_WIDTH-1:0] sin_v;
      logic signed [WORD_WIDTH-1:0] resid;
   } lane_type;

   typedef struct packed {
      logic                         valid;
      lane_type [NUM_AXES-1:0]      lane;
   } cell_data_type;

   // Q2.30 product, floor-shifted back to Q2.30. Operands stay near unit
   // magnitude, so the result fits the word.
   function automatic logic signed [WORD_WIDTH-1:0] fmul(
      input logic signed [WORD_WIDTH-1:0] a,
      input logic signed [WORD_WIDTH-1:0] b
   );
      logic signed [2*WORD_WIDTH-1:0] prod;
      prod = a * b;
      return prod[INNER_FRAC+WORD_WIDTH-1:INNER_FRAC];
   endfunction

endpackage

// ===== hw/rtl/e2q_channels.sv =====
// Valid/ready channel interfaces of the Euler-to-quaternion block: the request
// channel carrying three angles and the response channel carrying a quaternion.
`timescale 1ns / 1ps

interface e2q_req_if #(parameter int ANGLE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] roll_angle;
   logic signed [ANGLE_WIDTH-1:0] pitch_angle;
   logic signed [ANGLE_WIDTH-1:0] yaw_angle;

   modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_rsp_if #(parameter int FRACTION_BITS = 15);
   logic                          valid;
   logic                          ready;
   logic signed [FRACTION_BITS:0] quat_w;
   logic signed [FRACTION_BITS:0] quat_x;
   logic signed [FRACTION_BITS:0] quat_y;
   logic signed [FRACTION_BITS:0] quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== hw/rtl/e2q_cordic_cell.sv =====
// One CORDIC rotation step for all three axes, registered.
// Depends on e2q_pkg for the lane format and the arctangent table.
`timescale 1ns / 1ps

module e2q_cordic_cell
   import e2q_pkg::*;
#(
   parameter int STAGE_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  cell_data_type cell_in,
   output cell_data_type cell_out
);

   localparam logic signed [WORD_WIDTH-1:0] ATAN_STEP = ATAN_TABLE[STAGE_INDEX];

   logic                    valid_ff;
   logic                    valid_in;
   lane_type [NUM_AXES-1:0] lane_ff;
   lane_type [NUM_AXES-1:0] lane_in;

   always_comb begin
      valid_in = cell_in.valid;
      for (int a = 0; a < NUM_AXES; a++) begin
         // Rotate toward zero residual angle.
         if (!cell_in.lane[a].resid[WORD_WIDTH-1]) begin
            lane_in[a].cos_v = cell_in.lane[a].cos_v - (cell_in.lane[a].sin_v >>> STAGE_INDEX);
            lane_in[a].sin_v = cell_in.lane[a].sin_v + (cell_in.lane[a].cos_v >>> STAGE_INDEX);
            lane_in[a].resid = cell_in.lane[a].resid - ATAN_STEP;
         end else begin
            lane_in[a].cos_v = cell_in.lane[a].cos_v + (cell_in.lane[a].sin_v >>> STAGE_INDEX);
            lane_in[a].sin_v = cell_in.lane[a].sin_v - (cell_in.lane[a].cos_v >>> STAGE_INDEX);
            lane_in[a].resid = cell_in.lane[a].resid + ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.lane  = lane_ff;

endmodule

// ===== hw/rtl/e2q_combine.sv =====
// Quaternion assembly: two registered product stages over the CORDIC outputs,
// then the sums rounded and saturated to Q1.F. Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_combine
   import e2q_pkg::*;
#(
   parameter int FRACTION_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  cell_data_type                 cell_in,
   output logic                          out_valid,
   output logic signed [FRACTION_BITS:0] quat_w,
   output logic signed [FRACTION_BITS:0] quat_x,
   output logic signed [FRACTION_BITS:0] quat_y,
   output logic signed [FRACTION_BITS:0] quat_z
);

   localparam int SUM_WIDTH  = WORD_WIDTH + 2;
   localparam int RND_WIDTH  = WORD_WIDTH + 4;
   localparam int RND_SHIFT  = (FRACTION_BITS < INNER_FRAC) ? INNER_FRAC - FRACTION_BITS : 0;
   localparam int UP_SHIFT   = (FRACTION_BITS < INNER_FRAC) ? 0 : FRACTION_BITS - INNER_FRAC;
   localparam int HALF_POS   = (FRACTION_BITS < INNER_FRAC) ? INNER_FRAC - 1 - FRACTION_BITS : 0;
   localparam logic signed [RND_WIDTH-1:0] ROUND_HALF =
      (FRACTION_BITS < INNER_FRAC) ? (RND_WIDTH'(1) <<< HALF_POS) : RND_WIDTH'(0);
   localparam logic signed [RND_WIDTH-1:0] SAT_HI =
      (RND_WIDTH'(1) <<< FRACTION_BITS) - RND_WIDTH'(1);
   localparam logic signed [RND_WIDTH-1:0] SAT_LO = -(RND_WIDTH'(1) <<< FRACTION_BITS);

   // Round half up to the output grid, then clamp to the Q1.F range.
   function automatic logic signed [FRACTION_BITS:0] to_q(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [RND_WIDTH-1:0] r;
      r = ((RND_WIDTH'(v) + ROUND_HALF) >>> RND_SHIFT) <<< UP_SHIFT;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[FRACTION_BITS:0];
   endfunction

   logic                         s1_valid_ff;
   logic signed [WORD_WIDTH-1:0] cpcy_ff, spsy_ff, crsp_ff, srcp_ff, crcp_ff, srsp_ff;
   logic signed [WORD_WIDTH-1:0] cr_ff, sr_ff, cy_ff, sy_ff;

   logic                         s2_valid_ff;
   logic signed [WORD_WIDTH-1:0] w0_ff, w1_ff, x0_ff, x1_ff, y0_ff, y1_ff, z0_ff, z1_ff;

   logic signed [SUM_WIDTH-1:0]  sum_w, sum_x, sum_y, sum_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= cell_in.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // First products: pairs of axis terms.
   always_ff @(posedge clock) begin
      if (advance) begin
         cpcy_ff <= fmul(cell_in.lane[AXIS_PITCH].cos_v, cell_in.lane[AXIS_YAW].cos_v);
         spsy_ff <= fmul(cell_in.lane[AXIS_PITCH].sin_v, cell_in.lane[AXIS_YAW].sin_v);
         crsp_ff <= fmul(cell_in.lane[AXIS_ROLL].cos_v, cell_in.lane[AXIS_PITCH].sin_v);
         srcp_ff <= fmul(cell_in.lane[AXIS_ROLL].sin_v, cell_in.lane[AXIS_PITCH].cos_v);
         crcp_ff <= fmul(cell_in.lane[AXIS_ROLL].cos_v, cell_in.lane[AXIS_PITCH].cos_v);
         srsp_ff <= fmul(cell_in.lane[AXIS_ROLL].sin_v, cell_in.lane[AXIS_PITCH].sin_v);
         cr_ff   <= cell_in.lane[AXIS_ROLL].cos_v;
         sr_ff   <= cell_in.lane[AXIS_ROLL].sin_v;
         cy_ff   <= cell_in.lane[AXIS_YAW].cos_v;
         sy_ff   <= cell_in.lane[AXIS_YAW].sin_v;
      end
   end

   // Second products: the three-factor terms.
   always_ff @(posedge clock) begin
      if (advance) begin
         w0_ff <= fmul(cr_ff, cpcy_ff);
         w1_ff <= fmul(sr_ff, spsy_ff);
         x0_ff <= fmul(sr_ff, cpcy_ff);
         x1_ff <= fmul(cr_ff, spsy_ff);
         y0_ff <= fmul(crsp_ff, cy_ff);
         y1_ff <= fmul(srcp_ff, sy_ff);
         z0_ff <= fmul(crcp_ff, sy_ff);
         z1_ff <= fmul(srsp_ff, cy_ff);
      end
   end

   always_comb begin
      sum_w = SUM_WIDTH'(w0_ff) + SUM_WIDTH'(w1_ff);
      sum_x = SUM_WIDTH'(x0_ff) - SUM_WIDTH'(x1_ff);
      sum_y = SUM_WIDTH'(y0_ff) + SUM_WIDTH'(y1_ff);
      sum_z = SUM_WIDTH'(z0_ff) - SUM_WIDTH'(z1_ff);
   end

   assign out_valid = s2_valid_ff;
   assign quat_w    = to_q(sum_w);
   assign quat_x    = to_q(sum_x);
   assign quat_y    = to_q(sum_y);
   assign quat_z    = to_q(sum_z);

endmodule

// ===== hw/rtl/euler_to_quaternion_unit.sv =====
// Euler angles to orientation quaternion. Each request carries roll, pitch and
// yaw as signed binary angles (the top bit weight stands for pi). The unit
// halves each angle, runs it down a chain of CORDIC_STAGES registered rotation
// cells that produce cosine and sine for all three axes side by side, forms the
// quaternion from two registered rows of products, and rounds each component
// to signed Q1.FRACTION_BITS, saturating so that +1.0 reads as the largest
// positive code. The unit holds no state between requests and takes one request
// every clock cycle while the skid register is empty; a response passes through
// the CORDIC cells, both product rows and then the output register. The whole
// pipeline moves in lock step, and a two-entry output buffer (an output register
// plus a skid register) lets the request side keep accepting while a finished
// response waits, so the request ready depends only on registers. Depends on
// e2q_pkg, the channel interfaces and the assertion macros.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module euler_to_quaternion_unit
   import e2q_pkg::*;
#(
   parameter int ANGLE_WIDTH   = 16,
   parameter int FRACTION_BITS = 15,
   parameter int CORDIC_STAGES = 16
) (
   input  logic      clock,
   input  logic      reset,
   e2q_req_if.sink   req_chan,
   e2q_rsp_if.source rsp_chan
);

   localparam int OUT_WIDTH = FRACTION_BITS + 1;

   // The pipeline advances whenever the skid register is free.
   logic advance;

   cell_data_type chain [CORDIC_STAGES+1];

   logic                        comb_valid;
   logic signed [OUT_WIDTH-1:0] comb_w, comb_x, comb_y, comb_z;

   logic                        out_valid_ff, out_valid_in;
   logic signed [OUT_WIDTH-1:0] out_w_ff, out_x_ff, out_y_ff, out_z_ff;
   logic signed [OUT_WIDTH-1:0] out_w_in, out_x_in, out_y_in, out_z_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic signed [OUT_WIDTH-1:0] skid_w_ff, skid_x_ff, skid_y_ff, skid_z_ff;
   logic signed [OUT_WIDTH-1:0] skid_w_in, skid_x_in, skid_y_in, skid_z_in;

   logic arrive;
   logic out_take;

   // Scales an input angle to the 32-bit binary angle and halves it, which
   // keeps it within plus or minus pi/2 where CORDIC converges.
   function automatic logic signed [WORD_WIDTH-1:0] half_angle(
      input logic signed [ANGLE_WIDTH-1:0] angle
   );
      logic signed [WORD_WIDTH-1:0] scaled;
      scaled = WORD_WIDTH'(angle) <<< (WORD_WIDTH - ANGLE_WIDTH);
      return scaled >>> 1;
   endfunction

   assign advance        = !skid_valid_ff;
   assign req_chan.ready = advance;

   // Seed of the CORDIC chain: unit vector scaled by the inverse gain.
   always_comb begin
      chain[0].valid                 = req_chan.valid;
      chain[0].lane[AXIS_ROLL].resid  = half_angle(req_chan.roll_angle);
      chain[0].lane[AXIS_PITCH].resid = half_angle(req_chan.pitch_angle);
      chain[0].lane[AXIS_YAW].resid   = half_angle(req_chan.yaw_angle);
      for (int a = 0; a < NUM_AXES; a++) begin
         chain[0].lane[a].cos_v = INV_GAIN;
         chain[0].lane[a].sin_v = '0;
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      e2q_cordic_cell #(
         .STAGE_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   e2q_combine #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_combine (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cell_in   (chain[CORDIC_STAGES]),
      .out_valid (comb_valid),
      .quat_w    (comb_w),
      .quat_x    (comb_x),
      .quat_y    (comb_y),
      .quat_z    (comb_z)
   );

   // Output buffer. A finished quaternion goes to the output register when it
   // is free or being taken this cycle, otherwise to the skid register, which
   // then holds the pipeline until the output register drains.
   assign arrive   = comb_valid && advance;
   assign out_take = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_w_in      = out_w_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_z_in      = out_z_ff;
      skid_valid_in = skid_valid_ff;
      skid_w_in     = skid_w_ff;
      skid_x_in     = skid_x_ff;
      skid_y_in     = skid_y_ff;
      skid_z_in     = skid_z_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_w_in      = skid_w_ff;
            out_x_in      = skid_x_ff;
            out_y_in      = skid_y_ff;
            out_z_in      = skid_z_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_w_in     = comb_w;
            out_x_in     = comb_x;
            out_y_in     = comb_y;
            out_z_in     = comb_z;
         end else begin
            skid_valid_in = 1'b1;
            skid_w_in     = comb_w;
            skid_x_in     = comb_x;
            skid_y_in     = comb_y;
            skid_z_in     = comb_z;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_w_ff  <= out_w_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_z_ff  <= out_z_in;
      skid_w_ff <= skid_w_in;
      skid_x_ff <= skid_x_in;
      skid_y_ff <= skid_y_in;
      skid_z_ff <= skid_z_in;
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.quat_w = out_w_ff;
   assign rsp_chan.quat_x = out_x_ff;
   assign rsp_chan.quat_y = out_y_ff;
   assign rsp_chan.quat_z = out_z_ff;

   // The skid register only ever holds the second of two waiting responses.
   `ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid full while output empty")
   // The skid register fills only when the output register was stalled.
   `ASSERT_NEXT(a_skid_fill_on_stall, clock, reset, !skid_valid_ff && out_valid_ff && rsp_chan.ready, !skid_valid_ff, "skid filled although output drained")
   // A pending response is withdrawn only after the response side took it.
   `ASSERT_NEXT(a_out_drop_on_take, clock, reset, out_valid_ff && !rsp_chan.ready, out_valid_ff, "response dropped without handshake")

endmodule
